// ----- rtl/point_in_polygon_test_macros.svh -----
// Assertion macros shared by the point-in-polygon RTL.
// Depends on nothing; included by the modules that check their own logic.
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define PIP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pip assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define PIP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pip assertion failed");
`else
`define PIP_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define PIP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/pip_pkg.sv -----
// Shared types and constants of the point-in-polygon block.
// Depends on nothing; imported by every module of the block but the queue.
package pip_pkg;

   // Port field widths.
   localparam int FIELD_WIDTH     = 32;
   localparam int REQ_TDATA_WIDTH = 2 * FIELD_WIDTH;
   localparam int RSP_TDATA_WIDTH = 8;
   localparam int CSR_INDEX_WIDTH = 1;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_TEST_X = 1'b0,
      CSR_TEST_Y = 1'b1
   } csr_index_type;

   // Classification of one queued vertex.
   typedef struct packed {
      logic has_prev;   // an edge from the previous vertex closes here
      logic last;       // closing edge back to the first vertex, then a result
   } job_flags_type;

   // Per-edge flags found before the products.
   typedef struct packed {
      logic horiz;      // horizontal edge, no crossing test
      logic top_left;   // point level with the upper endpoint, left of both ends
      logic between;    // point strictly between the endpoint heights
   } edge_flag_type;

   // Outcome of one edge test.
   typedef struct packed {
      logic hit;        // point lies on the edge
      logic toggle;     // crossing parity flips
   } edge_res_type;

   // Control tag that travels beside the edge pipeline.
   typedef struct packed {
      logic valid;
      logic use0;
      logic last;
   } stage_tag_type;

endpackage

// ----- rtl/pip_queue.sv -----
// Small first-in first-out queue between the front and back parts.
// Depends on nothing but the shared assertion macros.
`include "point_in_polygon_test_macros.svh"
module pip_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push, pop;

   // Handshake on both sides.
   assign in_ready  = (cnt_ff != CNT_W'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = entry_ff[rd_ptr_ff];

   // Pointer wrap and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage is written at the tail.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

   `PIP_ASSERT_IMPLIES(a_queue_count_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(DEPTH))
   `PIP_ASSERT_NEXT(a_queue_push_fills, clock, reset, push, out_valid)

endmodule

// ----- rtl/pip_front.sv -----
// Front part: accepts vertex beats and pairs each with its previous and first vertex.
// Depends on pip_pkg for the job classification type.
module pip_front #(
   parameter int CW = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [CW-1:0]     in_x,
   input  logic [CW-1:0]     in_y,
   input  logic              in_last,
   input  logic              q_ready,
   output logic              push,
   output logic [6*CW+1:0]   job
);
   import pip_pkg::*;

   logic            have_first_ff, have_first_in;
   logic [CW-1:0]   first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic [CW-1:0]   prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [CW-1:0]   first_x_sel, first_y_sel;
   job_flags_type   flags;

   assign in_ready = q_ready;
   assign push     = in_valid && q_ready;

   // The first vertex of a polygon is its own first vertex.
   assign first_x_sel    = have_first_ff ? first_x_ff : in_x;
   assign first_y_sel    = have_first_ff ? first_y_ff : in_y;
   assign flags.has_prev = have_first_ff;
   assign flags.last     = in_last;
   assign job = {flags, first_y_sel, first_x_sel, in_y, in_x, prev_y_ff, prev_x_ff};

   // Vertex history; a last vertex starts a new polygon.
   always_comb begin
      have_first_in = have_first_ff;
      first_x_in    = first_x_ff;
      first_y_in    = first_y_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      if (push) begin
         have_first_in = !in_last;
         first_x_in    = first_x_sel;
         first_y_in    = first_y_sel;
         prev_x_in     = in_x;
         prev_y_in     = in_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_first_ff <= 1'b0;
      end else begin
         have_first_ff <= have_first_in;
      end
   end

   always_ff @(posedge clock) begin
      first_x_ff <= first_x_in;
      first_y_ff <= first_y_in;
      prev_x_ff  <= prev_x_in;
      prev_y_ff  <= prev_y_in;
   end

endmodule

// ----- rtl/pip_edge.sv -----
// Three-stage edge test: orientation and differences, products, then sign checks.
// Depends on pip_pkg for the edge flag and result types.
module pip_edge #(
   parameter int CW = 32
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [CW-1:0]  ax,
   input  logic signed [CW-1:0]  ay,
   input  logic signed [CW-1:0]  bx,
   input  logic signed [CW-1:0]  by,
   input  logic signed [CW-1:0]  mx,
   input  logic signed [CW-1:0]  my,
   output pip_pkg::edge_res_type res
);
   import pip_pkg::*;

   localparam int DW = CW + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 1;

   logic signed [CW-1:0] lo_x, lo_y, hi_x, hi_y, min_x;
   logic signed [DW-1:0] ux_in, uy_in, wx_in, wy_in;
   logic signed [DW-1:0] ux_ff, uy_ff, wx_ff, wy_ff;
   edge_flag_type        flag1_in, flag1_ff, flag2_ff;
   logic signed [PW-1:0] pxy_in, pyx_in, pxx_in, pyy_in;
   logic signed [PW-1:0] pxy_ff, pyx_ff, pxx_ff, pyy_ff;
   logic signed [SW-1:0] cross_p, dot;
   edge_res_type         res_in, res_ff;

   // Stage one: orient low to high in y, vectors from the point to both ends.
   always_comb begin
      if (ay > by) begin
         lo_x = bx;
         lo_y = by;
         hi_x = ax;
         hi_y = ay;
      end else begin
         lo_x = ax;
         lo_y = ay;
         hi_x = bx;
         hi_y = by;
      end
      min_x             = (ax < bx) ? ax : bx;
      ux_in             = DW'(lo_x) - DW'(mx);
      uy_in             = DW'(lo_y) - DW'(my);
      wx_in             = DW'(hi_x) - DW'(mx);
      wy_in             = DW'(hi_y) - DW'(my);
      flag1_in.horiz    = (ay == by);
      flag1_in.top_left = (my == hi_y) && (mx < min_x);
      flag1_in.between  = (my > lo_y) && (my < hi_y);
   end

   // Stage two: the four products, two for the cross and two for the dot.
   assign pxy_in = PW'(ux_ff) * PW'(wy_ff);
   assign pyx_in = PW'(uy_ff) * PW'(wx_ff);
   assign pxx_in = PW'(ux_ff) * PW'(wx_ff);
   assign pyy_in = PW'(uy_ff) * PW'(wy_ff);

   // Stage three: on-edge test and parity flip.
   always_comb begin
      cross_p       = SW'(pxy_ff) - SW'(pyx_ff);
      dot           = SW'(pxx_ff) + SW'(pyy_ff);
      res_in.hit    = (cross_p == '0) && (dot[SW-1] || (dot == '0));
      res_in.toggle = !flag2_ff.horiz &&
                      (flag2_ff.top_left ^
                       (flag2_ff.between && !cross_p[SW-1] && (cross_p != '0)));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ux_ff    <= ux_in;
         uy_ff    <= uy_in;
         wx_ff    <= wx_in;
         wy_ff    <= wy_in;
         flag1_ff <= flag1_in;
         pxy_ff   <= pxy_in;
         pyx_ff   <= pyx_in;
         pxx_ff   <= pxx_in;
         pyy_ff   <= pyy_in;
         flag2_ff <= flag1_ff;
         res_ff   <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// ----- rtl/pip_back.sv -----
// Back part: runs both edges of a queued vertex, keeps parity and hit, drives the result.
// Depends on pip_pkg, pip_edge and the shared assertion macros.
`include "point_in_polygon_test_macros.svh"
module pip_back #(
   parameter int CW = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_ready,
   input  logic [6*CW+1:0]      job,
   input  logic signed [CW-1:0] mx,
   input  logic signed [CW-1:0] my,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 inside_res,
   output logic                 on_boundary
);
   import pip_pkg::*;

   localparam int DEPTH = 3;

   logic                 en;
   job_flags_type        flags;
   logic signed [CW-1:0] prev_x, prev_y, cur_x, cur_y, first_x, first_y;
   edge_res_type         res0, res1, use_res0, use_res1;
   stage_tag_type        tag_ff [DEPTH];
   stage_tag_type        tag_in [DEPTH];
   stage_tag_type        tail;
   logic                 hit_ff, hit_in, par_ff, par_in;
   logic                 hit_sum, par_sum;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 inside_ff, inside_in, on_ff, on_in;

   // The whole back part moves unless a result waits to be taken.
   assign en        = !rsp_valid_ff || rsp_ready;
   assign job_ready = en;

   // Unpack the queue head.
   assign prev_x  = $signed(job[CW-1:0]);
   assign prev_y  = $signed(job[2*CW-1:CW]);
   assign cur_x   = $signed(job[3*CW-1:2*CW]);
   assign cur_y   = $signed(job[4*CW-1:3*CW]);
   assign first_x = $signed(job[5*CW-1:4*CW]);
   assign first_y = $signed(job[6*CW-1:5*CW]);
   assign flags   = job_flags_type'(job[6*CW+1:6*CW]);

   // Edge from the previous vertex, and the closing edge back to the first.
   pip_edge #(.CW(CW)) u_edge_prev (
      .clock (clock),
      .en    (en),
      .ax    (prev_x),
      .ay    (prev_y),
      .bx    (cur_x),
      .by    (cur_y),
      .mx    (mx),
      .my    (my),
      .res   (res0)
   );

   pip_edge #(.CW(CW)) u_edge_close (
      .clock (clock),
      .en    (en),
      .ax    (cur_x),
      .ay    (cur_y),
      .bx    (first_x),
      .by    (first_y),
      .mx    (mx),
      .my    (my),
      .res   (res1)
   );

   // Control tags travel beside the edge stages.
   always_comb begin
      tag_in[0].valid = job_valid;
      tag_in[0].use0  = flags.has_prev;
      tag_in[0].last  = flags.last;
      for (int i = 1; i < DEPTH; i++) begin
         tag_in[i] = tag_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            tag_ff[i] <= '0;
         end
      end else if (en) begin
         for (int i = 0; i < DEPTH; i++) begin
            tag_ff[i] <= tag_in[i];
         end
      end
   end

   assign tail = tag_ff[DEPTH-1];

   // Fold the edge outcomes into the polygon's parity and hit.
   always_comb begin
      use_res0     = tail.use0 ? res0 : '0;
      use_res1     = tail.last ? res1 : '0;
      hit_sum      = hit_ff | use_res0.hit | use_res1.hit;
      par_sum      = par_ff ^ use_res0.toggle ^ use_res1.toggle;
      hit_in       = hit_ff;
      par_in       = par_ff;
      inside_in    = inside_ff;
      on_in        = on_ff;
      rsp_valid_in = rsp_valid_ff;
      if (en) begin
         rsp_valid_in = tail.valid && tail.last;
         if (tail.valid) begin
            if (tail.last) begin
               hit_in    = 1'b0;
               par_in    = 1'b0;
               inside_in = hit_sum | par_sum;
               on_in     = hit_sum;
            end else begin
               hit_in = hit_sum;
               par_in = par_sum;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff       <= 1'b0;
         par_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hit_ff       <= hit_in;
         par_ff       <= par_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      inside_ff <= inside_in;
      on_ff     <= on_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign inside_res  = inside_ff;
   assign on_boundary = on_ff;

   `PIP_ASSERT_IMPLIES(a_boundary_is_inside, clock, reset, rsp_valid_ff, !on_ff || inside_ff)
   `PIP_ASSERT_NEXT(a_stall_holds_tail, clock, reset, !en, $stable(tag_ff[DEPTH-1]))

endmodule

// ----- rtl/point_in_polygon_test.sv -----
// Ray-casting point-in-polygon test. The point under test sits in two
// configuration registers; polygon vertices arrive one per beat on the req
// channel, and the beat flagged by tlast closes the polygon and yields one
// result beat on the rsp channel (inside or on the boundary, and on the
// boundary alone). The block takes one vertex every clock cycle while the
// queue has room: each vertex is queued, and a back-end pipeline tests its
// edge from the previous vertex and, on the last vertex, the closing edge
// back to the first one, with one edge unit per edge of four 33x33-bit
// products each. Without stalls, the last vertex passes through the queue,
// the edge stages and the result register before its result beat is
// presented. A waiting result freezes the back end, and the queue then
// fills up to QUEUE_DEPTH vertices before req_tready drops. Configuration
// must be written only while no vertex is queued or inside the edge pipeline.
module point_in_polygon_test #(
   parameter int COORD_WIDTH = 32,   // 8 to 32; coordinates use their low bits, signed
   parameter int QUEUE_DEPTH = 4     // vertices buffered between front and back
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // vertex_x [31:0], vertex_y [63:32]
   input  logic [pip_pkg::REQ_TDATA_WIDTH-1:0]   req_tdata,
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // inside_res [0], on_boundary [1], zero [7:2]
   output logic [pip_pkg::RSP_TDATA_WIDTH-1:0]   rsp_tdata,
   input  logic                                  csr_we,
   input  logic [pip_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [pip_pkg::FIELD_WIDTH-1:0]       csr_wdata
);
   import pip_pkg::*;

   localparam int JOB_W = 6 * COORD_WIDTH + 2;

   logic signed [COORD_WIDTH-1:0] test_x_ff, test_x_in, test_y_ff, test_y_in;
   logic [COORD_WIDTH-1:0]        vx, vy;
   logic                          q_ready, push, job_valid, job_ready;
   logic [JOB_W-1:0]              job_in, job_out;
   logic                          inside_res, on_boundary;

   // Test point registers.
   always_comb begin
      test_x_in = test_x_ff;
      test_y_in = test_y_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_TEST_X: test_x_in = $signed(csr_wdata[COORD_WIDTH-1:0]);
            CSR_TEST_Y: test_y_in = $signed(csr_wdata[COORD_WIDTH-1:0]);
            default:    test_x_in = test_x_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         test_x_ff <= '0;
         test_y_ff <= '0;
      end else begin
         test_x_ff <= test_x_in;
         test_y_ff <= test_y_in;
      end
   end

   // Vertex fields of the request beat.
   assign vx = req_tdata[COORD_WIDTH-1:0];
   assign vy = req_tdata[FIELD_WIDTH+COORD_WIDTH-1:FIELD_WIDTH];

   pip_front #(.CW(COORD_WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_x     (vx),
      .in_y     (vy),
      .in_last  (req_tlast),
      .q_ready  (q_ready),
      .push     (push),
      .job      (job_in)
   );

   pip_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push),
      .in_ready  (q_ready),
      .in_data   (job_in),
      .out_valid (job_valid),
      .out_ready (job_ready),
      .out_data  (job_out)
   );

   pip_back #(.CW(COORD_WIDTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (job_valid),
      .job_ready   (job_ready),
      .job         (job_out),
      .mx          (test_x_ff),
      .my          (test_y_ff),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .inside_res  (inside_res),
      .on_boundary (on_boundary)
   );

   // Result beat packing.
   assign rsp_tdata = {{(RSP_TDATA_WIDTH - 2){1'b0}}, on_boundary, inside_res};

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the point-in-polygon block point_in_polygon_test.
// Depends on pip_pkg for port widths and register indexes; the class below
// predicts each polygon verdict and compares it with the rsp channel.
module tb_top;
   import pip_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_VERTICES = 52;

   localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;

   // One polygon verdict as carried by an rsp beat.
   typedef struct {
      bit inside_res;
      bit on_boundary;
   } verdict_type;

   // Tracks the polygon being streamed and holds the verdicts still due.
   class polygon_checker;
      logic signed [31:0] point_x, point_y;
      logic signed [31:0] first_x, first_y, prev_x, prev_y;
      bit                 have_first, parity, hit;
      verdict_type        verdicts[$];
      int                 errors;

      function new();
         point_x = '0;
         point_y = '0;
         clear_polygon();
         errors = 0;
      endfunction

      function void clear_polygon();
         first_x = '0;
         first_y = '0;
         prev_x = '0;
         prev_y = '0;
         have_first = 0;
         parity = 0;
         hit = 0;
      endfunction

      function void write_point(csr_index_type index, logic [31:0] value);
         if (index == CSR_TEST_X) begin
            point_x = value;
         end else begin
            point_y = value;
         end
      endfunction

      // Boundary and ray-crossing test of one edge against the point.
      function void classify_edge(logic signed [31:0] ax0, logic signed [31:0] ay0,
                                  logic signed [31:0] bx0, logic signed [31:0] by0);
         logic signed [33:0] ax, ay, bx, by, mx, my, tmp, lo_x;
         logic signed [71:0] cross_p, dot;
         ax = ax0;
         ay = ay0;
         bx = bx0;
         by = by0;
         mx = point_x;
         my = point_y;
         // Orient the edge so that a is the lower endpoint.
         if (ay > by) begin
            tmp = ax; ax = bx; bx = tmp;
            tmp = ay; ay = by; by = tmp;
         end
         cross_p = (bx - ax) * (my - ay) - (by - ay) * (mx - ax);
         dot     = (ax - mx) * (bx - mx) + (ay - my) * (by - my);
         if (cross_p == 0 && dot <= 0)
            hit = 1;
         if (ay == by)
            return;
         lo_x = (ax < bx) ? ax : bx;
         if (my == by && mx < lo_x)
            parity = !parity;
         if (my == ay)
            return;
         if (my < by && my > ay) begin
            cross_p = (ax - mx) * (by - my) - (ay - my) * (bx - mx);
            if (cross_p > 0)
               parity = !parity;
         end
      endfunction

      // Called for every accepted vertex beat.
      function void note_vertex(logic signed [31:0] vx, logic signed [31:0] vy, bit last);
         verdict_type v;
         if (have_first) begin
            classify_edge(prev_x, prev_y, vx, vy);
         end else begin
            first_x = vx;
            first_y = vy;
            have_first = 1;
         end
         prev_x = vx;
         prev_y = vy;
         if (!last)
            return;
         // The closing edge back to the first vertex ends the polygon.
         classify_edge(vx, vy, first_x, first_y);
         v.inside_res = hit || parity;
         v.on_boundary = hit;
         verdicts.push_back(v);
         clear_polygon();
      endfunction

      // Called for every accepted result beat.
      function void check_verdict(logic [RSP_TDATA_WIDTH-1:0] beat);
         verdict_type want;
         if (verdicts.size() == 0) begin
            $error("result beat %h arrived with no verdict pending", beat);
            errors++;
            return;
         end
         want = verdicts.pop_front();
         if (beat[0] !== want.inside_res) begin
            $error("inside_res: expected %0d, actual %0b", want.inside_res, beat[0]);
            errors++;
         end
         if (beat[1] !== want.on_boundary) begin
            $error("on_boundary: expected %0d, actual %0b", want.on_boundary, beat[1]);
            errors++;
         end
         if (beat[RSP_TDATA_WIDTH-1:2] !== '0) begin
            $error("padding: expected 0, actual %h", beat[RSP_TDATA_WIDTH-1:2]);
            errors++;
         end
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   // vertex_x [31:0], vertex_y [63:32]
   logic [REQ_TDATA_WIDTH-1:0]  req_tdata = '0;
   logic                        req_tlast = 1'b0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   // inside_res [0], on_boundary [1], zero [7:2]
   logic [RSP_TDATA_WIDTH-1:0]  rsp_tdata;
   logic                        csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index = '0;
   logic [FIELD_WIDTH-1:0]      csr_wdata = '0;

   polygon_checker chk = new();
   bit             calm = 0;
   int             stall_left = 0;
   int             cycle_count = 0;

   point_in_polygon_test i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial forever #6 clock = ~clock;

   // Watch every handshake and the register port at each rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we)
            chk.write_point(csr_index_type'(csr_index), csr_wdata);
         if (req_tvalid && req_tready)
            chk.note_vertex(req_tdata[31:0], req_tdata[63:32], req_tlast);
         if (rsp_tvalid && rsp_tready)
            chk.check_verdict(rsp_tdata);
      end
   end

   // The receiver stalls in random bursts.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** point_in_polygon_test: FAILED **");
         $finish;
      end
   end

   // Present one vertex beat and hold it until it is taken.
   task automatic send_vertex(input logic signed [31:0] vx, input logic signed [31:0] vy,
                              input bit last);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {vy, vx};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_box(input logic signed [31:0] x0, input logic signed [31:0] y0,
                           input logic signed [31:0] x1, input logic signed [31:0] y1);
      send_vertex(x0, y0, 0);
      send_vertex(x1, y0, 0);
      send_vertex(x1, y1, 0);
      send_vertex(x0, y1, 1);
   endtask

   // Stop sending and wait for every pending verdict; optionally let the
   // back end run empty before the point registers change.
   task automatic wait_results(input bit settle);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (chk.verdicts.size() != 0) @(posedge clock);
      if (settle)
         repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_point(input logic signed [31:0] px, input logic signed [31:0] py);
      csr_we    <= 1'b1;
      csr_index <= CSR_TEST_X;
      csr_wdata <= px;
      @(posedge clock);
      csr_index <= CSR_TEST_Y;
      csr_wdata <= py;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Mostly coordinates a few steps from the point, so that edges often pass
   // through it or run along it; some full-range and extreme values too.
   function automatic logic signed [31:0] pick_coord(input logic signed [31:0] center);
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll < 14)
         return center + int'($urandom_range(0, 8)) - 4;
      if (roll < 17)
         return $urandom;
      if (roll == 17)
         return COORD_MIN;
      if (roll == 18)
         return COORD_MAX;
      return center;
   endfunction

   task automatic send_random_polygon(input logic signed [31:0] cx,
                                      input logic signed [31:0] cy, output int count);
      int pick;
      pick = $urandom_range(0, 9);
      count = (pick == 0) ? 1 : (pick == 1) ? 2 : $urandom_range(3, 7);
      for (int k = 0; k < count; k++)
         send_vertex(pick_coord(cx), pick_coord(cy), k == count - 1);
   endtask

   initial begin
      logic signed [31:0] px, py;
      int                 sent, count;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed polygons around the origin.
      load_point(0, 0);
      send_vertex(0, 0, 1);                   // single vertex on the point
      send_vertex(5, -7, 1);                  // single vertex away from it
      send_box(-2, -2, 2, 2);                 // point strictly inside
      send_box(3, 3, 5, 5);                   // point outside
      send_vertex(-4, 0, 0);                  // point on a horizontal edge
      send_vertex(4, 0, 0);
      send_vertex(0, 4, 1);
      send_box(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
      send_vertex(0, -3, 0);                  // diamond, ray through a vertex
      send_vertex(3, 0, 0);
      send_vertex(0, 3, 0);
      send_vertex(-3, 0, 1);
      send_vertex(2, -2, 0);                  // upper endpoint at the point's height
      send_vertex(4, 0, 0);
      send_vertex(2, 2, 1);
      wait_results(1);

      // Random polygons, one test point per phase, extremes first.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin px = COORD_MIN; py = COORD_MIN; end
            1: begin px = COORD_MAX; py = COORD_MAX; end
            2: begin px = COORD_MIN; py = COORD_MAX; end
            3: begin px = COORD_MAX; py = COORD_MIN; end
            4: begin px = 0; py = 0; end
            default: begin px = $urandom; py = $urandom; end
         endcase
         calm = (phase == RANDOM_PHASES - 1);
         load_point(px, py);
         sent = 0;
         while (sent < PHASE_VERTICES) begin
            send_random_polygon(px, py, count);
            sent += count;
            // Now and then hold off until the block has answered everything.
            if (!calm && $urandom_range(0, 14) == 0)
               wait_results(0);
         end
         wait_results(1);
      end

      if (chk.verdicts.size() != 0) begin
         $error("%0d verdicts never arrived", chk.verdicts.size());
         chk.errors++;
      end
      if (chk.errors == 0) begin
         $display("** point_in_polygon_test: PASSED **");
      end else begin
         $display("** point_in_polygon_test: FAILED **");
      end
      $finish;
   end
endmodule
